FILE: hdl/sphm_pkg.sv
// shared constants and types for the stride probing hash map
package sphm_pkg;

  localparam int TABLE_DEPTH    = 1024;
  localparam int STRIDE_DIVISOR = 8;
  localparam int KEY_BITS       = 48;
  localparam int IN_KEY_W       = 48;
  localparam int VALUE_W        = 64;
  localparam int CMD_W          = 2;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int STRIDE         = (TABLE_DEPTH / STRIDE_DIVISOR + 1) % TABLE_DEPTH;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_TOMB = 2'd1,
    KIND_LIVE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [KEY_BITS-1:0] key;
    logic [VALUE_W-1:0]  value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_RM_NEXT,
    ST_RM_BACK,
    ST_RESP
  } state_t;

  localparam idx_t STRIDE_IDX = idx_t'(STRIDE);

endpackage

FILE: hdl/sphm_ram.sv
// generic simple dual-port ram with registered read
module sphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: hdl/stride_probing_hash_map_core.sv
// Open-addressing key/value map with tombstones over one bucket ram. After reset
// the block sweeps the bucket ram, marking every bucket free, and takes no
// command meanwhile. A command is then taken in idle, visits one bucket per
// probe step (start at key mod depth, step by the odd stride), and hands its
// result to the output register; a remove that hits also looks at the following
// bucket and, when that bucket is free, frees the hit bucket and each tombstone
// behind it until a bucket that is not a tombstone ends the run. A result beat
// held at the output holds the block in its last step until the beat leaves.
// No new command is taken until the result has gone to the output register.
// The single read port of the bucket ram sets the pace of these steps.
module stride_probing_hash_map_core
  import sphm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [IN_KEY_W-1:0] in_key,
  input  logic [VALUE_W-1:0]  in_default_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VALUE_W-1:0]  out_value,
  output logic                out_hit,
  output logic                out_status
);

  state_t state_r, state_nxt;

  idx_t                clr_cnt_r, clr_cnt_nxt;
  idx_t                cur_r, cur_nxt;
  idx_t                start_r, start_nxt;
  idx_t                tomb_r, tomb_nxt;
  logic                tomb_vld_r, tomb_vld_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [VALUE_W-1:0]  dflt_r, dflt_nxt;
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                res_hit_r, res_hit_nxt;
  logic                res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic                out_status_r, out_status_nxt;

  logic   ram_we;
  idx_t   ram_waddr;
  entry_t ram_wdata;
  idx_t   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t rd_entry;

  idx_t next_idx, prev_idx;
  logic is_match, is_free, is_wrap, clr_done, out_free, accept;

  sphm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign next_idx = cur_r + STRIDE_IDX;
  assign prev_idx = cur_r - STRIDE_IDX;
  assign is_match = (rd_entry.kind == KIND_LIVE) && (rd_entry.key == key_r);
  assign is_free  = (rd_entry.kind == KIND_FREE);
  assign is_wrap  = (next_idx == start_r);
  assign clr_done = (clr_cnt_r == idx_t'(TABLE_DEPTH - 1));
  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_hit    = out_hit_r;
  assign out_status = out_status_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (is_match && cmd_r == CMD_REMOVE) begin
          state_nxt = ST_RM_NEXT;
        end else if (is_match || is_free || is_wrap) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RM_NEXT: begin
        state_nxt = (rd_entry.kind != KIND_FREE) ? ST_RESP : ST_RM_BACK;
      end
      ST_RM_BACK: begin
        if (rd_entry.kind != KIND_TOMB) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    tomb_nxt       = tomb_r;
    tomb_vld_nxt   = tomb_vld_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    dflt_nxt       = dflt_r;
    res_value_nxt  = res_value_r;
    res_hit_nxt    = res_hit_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_hit_nxt    = out_hit_r;
    out_status_nxt = out_status_r;
    ram_we          = 1'b0;
    ram_waddr       = cur_r;
    ram_wdata.kind  = KIND_FREE;
    ram_wdata.key   = key_r;
    ram_wdata.value = dflt_r;
    ram_raddr       = next_idx;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + idx_t'(1);
      end
      ST_IDLE: begin
        ram_raddr = in_key[IDX_W-1:0];
        if (accept) begin
          cur_nxt        = in_key[IDX_W-1:0];
          start_nxt      = in_key[IDX_W-1:0];
          tomb_vld_nxt   = 1'b0;
          cmd_nxt        = cmd_t'(in_cmd);
          key_nxt        = in_key[KEY_BITS-1:0];
          dflt_nxt       = in_default_value;
          res_value_nxt  = in_default_value;
          res_hit_nxt    = 1'b0;
          res_status_nxt = 1'b0;
        end
      end
      ST_PROBE: begin
        if (is_match) begin
          res_hit_nxt   = 1'b1;
          res_value_nxt = rd_entry.value;
        end else if (is_free || is_wrap) begin
          if (cmd_r == CMD_ADD) begin
            if (tomb_vld_r || is_free) begin
              ram_we         = 1'b1;
              ram_waddr      = tomb_vld_r ? tomb_r : cur_r;
              ram_wdata.kind = KIND_LIVE;
            end else if (rd_entry.kind == KIND_TOMB) begin
              ram_we         = 1'b1;
              ram_wdata.kind = KIND_LIVE;
            end else begin
              res_status_nxt = 1'b1;
            end
          end
        end else begin
          if (rd_entry.kind == KIND_TOMB && !tomb_vld_r) begin
            tomb_nxt     = cur_r;
            tomb_vld_nxt = 1'b1;
          end
          cur_nxt = next_idx;
        end
      end
      ST_RM_NEXT: begin
        ram_we    = 1'b1;
        ram_raddr = prev_idx;
        if (rd_entry.kind != KIND_FREE) begin
          ram_wdata.kind = KIND_TOMB;
        end else begin
          cur_nxt = prev_idx;
        end
      end
      ST_RM_BACK: begin
        ram_raddr = prev_idx;
        if (rd_entry.kind == KIND_TOMB) begin
          ram_we  = 1'b1;
          cur_nxt = prev_idx;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_hit_nxt    = res_hit_r;
          out_status_nxt = res_status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      tomb_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      tomb_vld_r  <= tomb_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    tomb_r       <= tomb_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    dflt_r       <= dflt_nxt;
    res_value_r  <= res_value_nxt;
    res_hit_r    <= res_hit_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_hit_r    <= out_hit_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
